/* rtl/cubic_bezier_split_assert.svh */
// ----------------------------------------------------------------------------
// Cubic Bezier split assertion macros
// Shared concurrent assertion forms, clocked on aclk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef CUBIC_BEZIER_SPLIT_ASSERT_SVH
`define CUBIC_BEZIER_SPLIT_ASSERT_SVH

// Property that must hold in the same cycle as its trigger.
`define CBS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
    else $error(msg);

// Property that must hold in the cycle after its trigger.
`define CBS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/cbs_pkg.sv */
// ----------------------------------------------------------------------------
// Cubic Bezier split package
// Widths, lane word types and the output saturation function.
// ----------------------------------------------------------------------------
package cbs_pkg;

    // Coordinate widths: inputs and results, internal points, differences.
    localparam int COORD_W = 32;
    localparam int PT_W    = 33;
    localparam int DIFF_W  = 34;
    localparam int T_IN_W  = 17;

    // Stream word widths, padded to whole bytes.
    localparam int S_DATA_W = 280;
    localparam int M_DATA_W = 320;

    // Lane pipeline stages, plus the output register.
    localparam int LANE_STAGES = 10;
    localparam int PIPE_DEPTH  = LANE_STAGES + 1;

    // Saturation bounds in the difference width.
    localparam logic signed [DIFF_W-1:0] SAT_MAX =
        {{(DIFF_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}};
    localparam logic signed [DIFF_W-1:0] SAT_MIN =
        {{(DIFF_W-COORD_W+1){1'b1}}, {(COORD_W-1){1'b0}}};

    typedef logic signed [COORD_W-1:0] coord_t;

    // One axis of an input word.
    typedef struct packed {
        coord_t p_end;
        coord_t handle_in;
        coord_t handle_out;
        coord_t p_start;
    } lane_in_t;

    // One axis of a result word.
    typedef struct packed {
        coord_t mid_out;
        coord_t mid_in;
        coord_t mid;
        coord_t new_in;
        coord_t new_out;
    } lane_out_t;

    // Clamp a difference-width value into the coordinate range.
    function automatic coord_t sat_coord(input logic signed [DIFF_W-1:0] v);
        coord_t r;
        if (v > SAT_MAX) begin
            r = SAT_MAX[COORD_W-1:0];
        end else if (v < SAT_MIN) begin
            r = SAT_MIN[COORD_W-1:0];
        end else begin
            r = v[COORD_W-1:0];
        end
        return r;
    endfunction

endpackage

/* rtl/cubic_bezier_split.sv */
// ----------------------------------------------------------------------------
// Cubic Bezier split
// De Casteljau subdivision of one cubic segment at t, x and y in two lanes.
//
//   Channel   Direction  Word
//   s_        in         P0, out-handle, in-handle, P1 (x and y), split t
//   m_        out        new handles, split point and its two handles
//
// One word is accepted per cycle unless a stalled result has filled every stage.
// The pipeline length is set by three interpolation levels of three stages each
// (difference, multiply, round and add), one control point stage and the
// output register. Reset empties the pipeline and needs no further cycles.
// A stalled result holds the output; bubbles inside still close up, so new
// words are taken until every stage holds one.
// ----------------------------------------------------------------------------
module cubic_bezier_split #(
    parameter int FRAC_BITS = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // p_start_x, p_start_y, handle_out_x, handle_out_y, handle_in_x,
    // handle_in_y, p_end_x, p_end_y, split_t, then zero padding
    input  logic [cbs_pkg::S_DATA_W-1:0]   s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // new_out_x, new_out_y, new_in_x, new_in_y, mid_x, mid_y,
    // mid_in_x, mid_in_y, mid_out_x, mid_out_y
    output logic [cbs_pkg::M_DATA_W-1:0]   m_tdata
);

    localparam int DEPTH = cbs_pkg::PIPE_DEPTH;
    localparam int OUT   = DEPTH - 1;
    localparam int T_W   = (FRAC_BITS + 1 > cbs_pkg::T_IN_W) ? FRAC_BITS + 1
                                                              : cbs_pkg::T_IN_W;
    localparam int CW    = cbs_pkg::COORD_W;

    logic [DEPTH-1:0]              valid_reg;
    logic [DEPTH-1:0]              valid_next;
    logic [DEPTH-1:0]              en;
    cbs_pkg::lane_in_t             x_in;
    cbs_pkg::lane_in_t             y_in;
    cbs_pkg::lane_out_t            x_out;
    cbs_pkg::lane_out_t            y_out;
    logic [cbs_pkg::T_IN_W-1:0]    split_t;
    logic [cbs_pkg::M_DATA_W-1:0]  m_tdata_reg;
    logic [cbs_pkg::M_DATA_W-1:0]  m_tdata_next;

    // A stage advances when it is empty or the stage after it advances.
    always_comb begin
        en[OUT] = !valid_reg[OUT] || m_tready;
        for (int k = OUT - 1; k >= 0; k--) begin
            en[k] = !valid_reg[k] || en[k+1];
        end
        valid_next[0] = en[0] ? s_tvalid : valid_reg[0];
        for (int k = 1; k < DEPTH; k++) begin
            valid_next[k] = en[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Split the input word into the two axes.
    always_comb begin
        x_in.p_start    = s_tdata[0*CW +: CW];
        y_in.p_start    = s_tdata[1*CW +: CW];
        x_in.handle_out = s_tdata[2*CW +: CW];
        y_in.handle_out = s_tdata[3*CW +: CW];
        x_in.handle_in  = s_tdata[4*CW +: CW];
        y_in.handle_in  = s_tdata[5*CW +: CW];
        x_in.p_end      = s_tdata[6*CW +: CW];
        y_in.p_end      = s_tdata[7*CW +: CW];
    end
    assign split_t = s_tdata[8*CW +: cbs_pkg::T_IN_W];

    cbs_lane #(.FRAC_BITS(FRAC_BITS), .T_W(T_W)) u_lane_x (
        .aclk(aclk), .en(en[OUT-1:0]), .lane_in(x_in), .split_t(split_t),
        .lane_out(x_out)
    );

    cbs_lane #(.FRAC_BITS(FRAC_BITS), .T_W(T_W)) u_lane_y (
        .aclk(aclk), .en(en[OUT-1:0]), .lane_in(y_in), .split_t(split_t),
        .lane_out(y_out)
    );

    // Merge the two lanes into one result word, x before y for each field.
    assign m_tdata_next = {y_out.mid_out, x_out.mid_out,
                           y_out.mid_in,  x_out.mid_in,
                           y_out.mid,     x_out.mid,
                           y_out.new_in,  x_out.new_in,
                           y_out.new_out, x_out.new_out};

    always_ff @(posedge aclk) begin
        if (en[OUT]) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign s_tready = en[0];
    assign m_tvalid = valid_reg[OUT];
    assign m_tdata  = m_tdata_reg;

endmodule

/* rtl/cbs_lerp.sv */
// ----------------------------------------------------------------------------
// Cubic Bezier split interpolation unit
// Three-stage pipelined a + round((b - a) * t), ties toward plus infinity.
// ----------------------------------------------------------------------------
module cbs_lerp #(
    parameter int FRAC_BITS = 16,
    parameter int T_W       = 17
) (
    input  logic                             aclk,
    input  logic [2:0]                       en,
    input  logic signed [cbs_pkg::PT_W-1:0]  a_in,
    input  logic signed [cbs_pkg::PT_W-1:0]  b_in,
    input  logic [T_W-1:0]                   t_in,
    output logic signed [cbs_pkg::PT_W-1:0]  y_out
);

    localparam int PROD_W = cbs_pkg::DIFF_W + T_W + 1;
    localparam logic signed [PROD_W:0] HALF =
        {{(PROD_W-FRAC_BITS+1){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};

    logic signed [cbs_pkg::DIFF_W-1:0] diff_reg;
    logic signed [cbs_pkg::DIFF_W-1:0] diff_next;
    logic signed [cbs_pkg::PT_W-1:0]   a1_reg;
    logic [T_W-1:0]                    t1_reg;
    logic signed [PROD_W-1:0]          prod_reg;
    logic signed [PROD_W-1:0]          prod_next;
    logic signed [cbs_pkg::PT_W-1:0]   a2_reg;
    logic signed [PROD_W:0]            rnd;
    logic signed [PROD_W:0]            step;
    logic signed [cbs_pkg::PT_W-1:0]   y_reg;
    logic signed [cbs_pkg::PT_W-1:0]   y_next;

    // Stage one: span between the two points.
    assign diff_next = {b_in[cbs_pkg::PT_W-1], b_in} - {a_in[cbs_pkg::PT_W-1], a_in};

    // Stage two: scale the span by t, t taken as a non-negative value.
    assign prod_next = diff_reg * $signed({1'b0, t1_reg});

    // Stage three: round to nearest, arithmetic shift floors, add the base.
    assign rnd    = {prod_reg[PROD_W-1], prod_reg} + HALF;
    assign step   = rnd >>> FRAC_BITS;
    assign y_next = a2_reg + step[cbs_pkg::PT_W-1:0];

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            diff_reg <= diff_next;
            a1_reg   <= a_in;
            t1_reg   <= t_in;
        end
        if (en[1]) begin
            prod_reg <= prod_next;
            a2_reg   <= a1_reg;
        end
        if (en[2]) begin
            y_reg <= y_next;
        end
    end

    assign y_out = y_reg;

endmodule

/* rtl/cbs_lane.sv */
// ----------------------------------------------------------------------------
// Cubic Bezier split axis lane
// Ten-stage pipeline for one axis: control points, three interpolation
// levels, then relative handles with saturation at the lane output.
// ----------------------------------------------------------------------------
module cbs_lane #(
    parameter int FRAC_BITS = 16,
    parameter int T_W       = 17
) (
    input  logic                              aclk,
    input  logic [cbs_pkg::LANE_STAGES-1:0]   en,
    input  cbs_pkg::lane_in_t                 lane_in,
    input  logic [cbs_pkg::T_IN_W-1:0]        split_t,
    output cbs_pkg::lane_out_t                lane_out
);

    localparam int LAST  = cbs_pkg::LANE_STAGES - 1;
    localparam int L2_IN = 3;
    localparam int L3_IN = 6;
    localparam logic [T_W-1:0] T_ONE = T_W'(1) << FRAC_BITS;

    logic [T_W-1:0]                   t_ext;
    logic [T_W-1:0]                   t_clamp;
    logic [T_W-1:0]                   t_pipe_reg [0:L3_IN];
    cbs_pkg::coord_t                  p0_pipe_reg [0:LAST];
    cbs_pkg::coord_t                  p1_pipe_reg [0:LAST];
    logic signed [cbs_pkg::PT_W-1:0]  c0_reg;
    logic signed [cbs_pkg::PT_W-1:0]  c1_reg;
    logic signed [cbs_pkg::PT_W-1:0]  c0_next;
    logic signed [cbs_pkg::PT_W-1:0]  c1_next;
    logic signed [cbs_pkg::PT_W-1:0]  p0_pt;
    logic signed [cbs_pkg::PT_W-1:0]  p1_pt;
    logic signed [cbs_pkg::PT_W-1:0]  a_pt;
    logic signed [cbs_pkg::PT_W-1:0]  b_pt;
    logic signed [cbs_pkg::PT_W-1:0]  c_pt;
    logic signed [cbs_pkg::PT_W-1:0]  d_pt;
    logic signed [cbs_pkg::PT_W-1:0]  e_pt;
    logic signed [cbs_pkg::PT_W-1:0]  f_pt;
    logic signed [cbs_pkg::PT_W-1:0]  a_dly_reg [L2_IN+1:LAST];
    logic signed [cbs_pkg::PT_W-1:0]  c_dly_reg [L2_IN+1:LAST];
    logic signed [cbs_pkg::PT_W-1:0]  d_dly_reg [L3_IN+1:LAST];
    logic signed [cbs_pkg::PT_W-1:0]  e_dly_reg [L3_IN+1:LAST];
    logic [cbs_pkg::DIFF_W-1:0]       p0_end;
    logic [cbs_pkg::DIFF_W-1:0]       p1_end;
    logic [cbs_pkg::DIFF_W-1:0]       f_end;

    // Stage zero: clamp t to one and form the absolute control points.
    assign t_ext   = T_W'(split_t);
    assign t_clamp = (t_ext > T_ONE) ? T_ONE : t_ext;
    assign c0_next = {lane_in.p_start[cbs_pkg::COORD_W-1], lane_in.p_start}
                   + {lane_in.handle_out[cbs_pkg::COORD_W-1], lane_in.handle_out};
    assign c1_next = {lane_in.p_end[cbs_pkg::COORD_W-1], lane_in.p_end}
                   + {lane_in.handle_in[cbs_pkg::COORD_W-1], lane_in.handle_in};

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            c0_reg         <= c0_next;
            c1_reg         <= c1_next;
            t_pipe_reg[0]  <= t_clamp;
            p0_pipe_reg[0] <= lane_in.p_start;
            p1_pipe_reg[0] <= lane_in.p_end;
        end
        for (int k = 1; k <= L3_IN; k++) begin
            if (en[k]) begin
                t_pipe_reg[k] <= t_pipe_reg[k-1];
            end
        end
        for (int k = 1; k <= LAST; k++) begin
            if (en[k]) begin
                p0_pipe_reg[k] <= p0_pipe_reg[k-1];
                p1_pipe_reg[k] <= p1_pipe_reg[k-1];
            end
        end
    end

    assign p0_pt = {p0_pipe_reg[0][cbs_pkg::COORD_W-1], p0_pipe_reg[0]};
    assign p1_pt = {p1_pipe_reg[0][cbs_pkg::COORD_W-1], p1_pipe_reg[0]};

    // First level: A, B and C, stages one to three.
    cbs_lerp #(.FRAC_BITS(FRAC_BITS), .T_W(T_W)) u_lerp_a (
        .aclk(aclk), .en(en[3:1]), .a_in(p0_pt), .b_in(c0_reg),
        .t_in(t_pipe_reg[0]), .y_out(a_pt)
    );
    cbs_lerp #(.FRAC_BITS(FRAC_BITS), .T_W(T_W)) u_lerp_b (
        .aclk(aclk), .en(en[3:1]), .a_in(c0_reg), .b_in(c1_reg),
        .t_in(t_pipe_reg[0]), .y_out(b_pt)
    );
    cbs_lerp #(.FRAC_BITS(FRAC_BITS), .T_W(T_W)) u_lerp_c (
        .aclk(aclk), .en(en[3:1]), .a_in(c1_reg), .b_in(p1_pt),
        .t_in(t_pipe_reg[0]), .y_out(c_pt)
    );

    // Second level: D and E, stages four to six.
    cbs_lerp #(.FRAC_BITS(FRAC_BITS), .T_W(T_W)) u_lerp_d (
        .aclk(aclk), .en(en[6:4]), .a_in(a_pt), .b_in(b_pt),
        .t_in(t_pipe_reg[L2_IN]), .y_out(d_pt)
    );
    cbs_lerp #(.FRAC_BITS(FRAC_BITS), .T_W(T_W)) u_lerp_e (
        .aclk(aclk), .en(en[6:4]), .a_in(b_pt), .b_in(c_pt),
        .t_in(t_pipe_reg[L2_IN]), .y_out(e_pt)
    );

    // Third level: F, the curve point, stages seven to nine.
    cbs_lerp #(.FRAC_BITS(FRAC_BITS), .T_W(T_W)) u_lerp_f (
        .aclk(aclk), .en(en[9:7]), .a_in(d_pt), .b_in(e_pt),
        .t_in(t_pipe_reg[L3_IN]), .y_out(f_pt)
    );

    // Carry A, C, D and E along until F is ready.
    always_ff @(posedge aclk) begin
        if (en[L2_IN+1]) begin
            a_dly_reg[L2_IN+1] <= a_pt;
            c_dly_reg[L2_IN+1] <= c_pt;
        end
        for (int k = L2_IN + 2; k <= LAST; k++) begin
            if (en[k]) begin
                a_dly_reg[k] <= a_dly_reg[k-1];
                c_dly_reg[k] <= c_dly_reg[k-1];
            end
        end
        if (en[L3_IN+1]) begin
            d_dly_reg[L3_IN+1] <= d_pt;
            e_dly_reg[L3_IN+1] <= e_pt;
        end
        for (int k = L3_IN + 2; k <= LAST; k++) begin
            if (en[k]) begin
                d_dly_reg[k] <= d_dly_reg[k-1];
                e_dly_reg[k] <= e_dly_reg[k-1];
            end
        end
    end

    // Relative handles and the split point, each clamped to the coordinate range.
    assign p0_end = {{2{p0_pipe_reg[LAST][cbs_pkg::COORD_W-1]}}, p0_pipe_reg[LAST]};
    assign p1_end = {{2{p1_pipe_reg[LAST][cbs_pkg::COORD_W-1]}}, p1_pipe_reg[LAST]};
    assign f_end  = {f_pt[cbs_pkg::PT_W-1], f_pt};

    always_comb begin
        lane_out.new_out = cbs_pkg::sat_coord(
            {a_dly_reg[LAST][cbs_pkg::PT_W-1], a_dly_reg[LAST]} - p0_end);
        lane_out.new_in  = cbs_pkg::sat_coord(
            {c_dly_reg[LAST][cbs_pkg::PT_W-1], c_dly_reg[LAST]} - p1_end);
        lane_out.mid     = cbs_pkg::sat_coord(f_end);
        lane_out.mid_in  = cbs_pkg::sat_coord(
            {d_dly_reg[LAST][cbs_pkg::PT_W-1], d_dly_reg[LAST]} - f_end);
        lane_out.mid_out = cbs_pkg::sat_coord(
            {e_dly_reg[LAST][cbs_pkg::PT_W-1], e_dly_reg[LAST]} - f_end);
    end

endmodule

/* rtl/cbs_checker.sv */
// ----------------------------------------------------------------------------
// Cubic Bezier split port checker
// Watches the stream ports: output hold, back pressure and word count.
// ----------------------------------------------------------------------------
`include "cubic_bezier_split_assert.svh"

module cbs_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [cbs_pkg::M_DATA_W-1:0]  m_tdata
);

    localparam int OCC_W = $clog2(cbs_pkg::PIPE_DEPTH + 1);
    localparam logic [OCC_W-1:0] OCC_MAX = OCC_W'(cbs_pkg::PIPE_DEPTH);

    logic [OCC_W-1:0] occ_reg;
    logic [OCC_W-1:0] occ_next;
    logic             in_word;
    logic             out_word;

    // Words inside the block: accepted in, not yet taken out.
    assign in_word  = s_tvalid && s_tready;
    assign out_word = m_tvalid && m_tready;

    always_comb begin
        occ_next = occ_reg;
        if (in_word && !out_word) begin
            occ_next = occ_reg + OCC_W'(1);
        end else if (out_word && !in_word) begin
            occ_next = occ_reg - OCC_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= '0;
        end else begin
            occ_reg <= occ_next;
        end
    end

    // A stalled result keeps its word.
    `CBS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result word changed while stalled")

    // The input only pushes back when the output is stalled.
    `CBS_ASSERT_NOW(a_full_stall, !s_tready, m_tvalid && !m_tready, "input stalled without output back pressure")

    // Every result stems from an accepted word.
    `CBS_ASSERT_NOW(a_no_phantom, m_tvalid, occ_reg != '0 || (s_tvalid && s_tready), "result with no word inside")

    // No more words inside than the pipeline has stages.
    `CBS_ASSERT_NOW(a_occ_bound, 1'b1, occ_reg <= OCC_MAX, "more words inside than stages")

endmodule

bind cubic_bezier_split cbs_checker u_cbs_checker (.*);

/* bench/tb_cubic_bezier_split.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Cubic Bezier split testbench
// Sends segment words into the splitter and predicts each result word with
// a wide-integer de Casteljau model. Results are checked field by field, in
// order, and in some phases both sides of the stream stall at random.
// ----------------------------------------------------------------------------
module tb_cubic_bezier_split;

    localparam int     FRAC_BITS   = 16;
    localparam int     T_ONE       = 1 << FRAC_BITS;
    localparam longint T_HALF      = longint'(1) << (FRAC_BITS - 1);
    localparam longint COORD_MAX   = 64'sd2147483647;
    localparam longint COORD_MIN   = -64'sd2147483648;
    localparam int     N_RESULTS   = 10;
    localparam int     CYCLE_LIMIT = 200000;
    localparam int     PRINT_CAP   = 40;
    localparam int     COORD_W     = cbs_pkg::COORD_W;
    localparam int     T_IN_W      = cbs_pkg::T_IN_W;
    localparam int     PIPE_DEPTH  = cbs_pkg::PIPE_DEPTH;

    typedef cbs_pkg::coord_t coord_t;
    typedef logic [cbs_pkg::S_DATA_W-1:0] seg_word_t;
    typedef logic [cbs_pkg::M_DATA_W-1:0] split_word_t;

    // One segment as the input word carries it.
    typedef struct {
        coord_t              p_start_x;
        coord_t              p_start_y;
        coord_t              handle_out_x;
        coord_t              handle_out_y;
        coord_t              handle_in_x;
        coord_t              handle_in_y;
        coord_t              p_end_x;
        coord_t              p_end_y;
        logic [T_IN_W-1:0]   t_param;
    } segment_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    seg_word_t   s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    split_word_t m_tdata;

    split_word_t split_expect_q[$];
    int          mismatch_count = 0;
    int          cycle_count    = 0;
    bit          feed_idle_en   = 1'b0;
    bit          sink_idle_en   = 1'b0;
    int          sink_hold_len  = 0;

    string FIELD_NAME [N_RESULTS] = '{
        "new_out_x", "new_out_y", "new_in_x", "new_in_y", "mid_x", "mid_y",
        "mid_in_x", "mid_in_y", "mid_out_x", "mid_out_y"
    };

    cubic_bezier_split #(
        .FRAC_BITS(FRAC_BITS)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Clock with a 10 ns period.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Watchdog: a hung pipeline ends the run as a failure.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // One interpolation step, rounded to nearest with ties toward plus infinity.
    function automatic longint lerp_q(input longint a, input longint b, input longint t);
        longint diff;
        diff = b - a;
        return a + ((diff * t + T_HALF) >>> FRAC_BITS);
    endfunction

    function automatic coord_t clamp_coord(input longint v);
        if (v > COORD_MAX) begin
            return coord_t'(COORD_MAX);
        end else if (v < COORD_MIN) begin
            return coord_t'(COORD_MIN);
        end
        return coord_t'(v);
    endfunction

    // Subdivide one axis. Control points are kept exact; only results clamp.
    function automatic void split_axis(
        input  longint p0, input longint ho, input longint hi, input longint p1,
        input  longint t,
        output coord_t new_out, output coord_t new_in, output coord_t mid,
        output coord_t mid_in, output coord_t mid_out
    );
        longint c0, c1, a, b, c, d, e, f;
        c0 = p0 + ho;
        c1 = p1 + hi;
        a  = lerp_q(p0, c0, t);
        b  = lerp_q(c0, c1, t);
        c  = lerp_q(c1, p1, t);
        d  = lerp_q(a, b, t);
        e  = lerp_q(b, c, t);
        f  = lerp_q(d, e, t);
        new_out = clamp_coord(a - p0);
        new_in  = clamp_coord(c - p1);
        mid     = clamp_coord(f);
        mid_in  = clamp_coord(d - f);
        mid_out = clamp_coord(e - f);
    endfunction

    // Expected result word for one segment; t above one acts as one.
    function automatic split_word_t predict_split(input segment_t s);
        longint      t;
        coord_t      r [N_RESULTS];
        split_word_t w;
        t = (s.t_param > T_ONE) ? longint'(T_ONE) : longint'(s.t_param);
        split_axis(s.p_start_x, s.handle_out_x, s.handle_in_x, s.p_end_x, t,
                   r[0], r[2], r[4], r[6], r[8]);
        split_axis(s.p_start_y, s.handle_out_y, s.handle_in_y, s.p_end_y, t,
                   r[1], r[3], r[5], r[7], r[9]);
        w = '0;
        for (int i = 0; i < N_RESULTS; i++) begin
            w[i*COORD_W +: COORD_W] = r[i];
        end
        return w;
    endfunction

    function automatic seg_word_t pack_segment(input segment_t s);
        seg_word_t w;
        w = '0;
        w[0*COORD_W +: COORD_W] = s.p_start_x;
        w[1*COORD_W +: COORD_W] = s.p_start_y;
        w[2*COORD_W +: COORD_W] = s.handle_out_x;
        w[3*COORD_W +: COORD_W] = s.handle_out_y;
        w[4*COORD_W +: COORD_W] = s.handle_in_x;
        w[5*COORD_W +: COORD_W] = s.handle_in_y;
        w[6*COORD_W +: COORD_W] = s.p_end_x;
        w[7*COORD_W +: COORD_W] = s.p_end_y;
        w[8*COORD_W +: T_IN_W]  = s.t_param;
        return w;
    endfunction

    function automatic segment_t make_segment(
        input coord_t p0x, input coord_t p0y, input coord_t hox, input coord_t hoy,
        input coord_t hix, input coord_t hiy, input coord_t p1x, input coord_t p1y,
        input logic [T_IN_W-1:0] t
    );
        segment_t s;
        s.p_start_x    = p0x;
        s.p_start_y    = p0y;
        s.handle_out_x = hox;
        s.handle_out_y = hoy;
        s.handle_in_x  = hix;
        s.handle_in_y  = hiy;
        s.p_end_x      = p1x;
        s.p_end_y      = p1y;
        s.t_param      = t;
        return s;
    endfunction

    // ------------------------------------------------------------------
    // Random values
    // ------------------------------------------------------------------

    // Full-range values, with extremes and small values mixed in.
    function automatic coord_t rand_coord();
        case ($urandom_range(0, 7))
            0: begin
                return 32'sh7FFF_FFFF;
            end
            1: begin
                return 32'sh8000_0000;
            end
            2: begin
                return coord_t'($urandom_range(0, 2**21)) - coord_t'(2**20);
            end
            3: begin
                return 32'sh7FFF_FFFF - coord_t'($urandom_range(0, 255));
            end
            4: begin
                return 32'sh8000_0000 + coord_t'($urandom_range(0, 255));
            end
            default: begin
                return coord_t'($urandom);
            end
        endcase
    endfunction

    function automatic logic [T_IN_W-1:0] rand_t_param();
        case ($urandom_range(0, 7))
            0: begin
                return '0;
            end
            1: begin
                return T_IN_W'(T_ONE);
            end
            2: begin
                return T_IN_W'($urandom_range(T_ONE + 1, (1 << T_IN_W) - 1));
            end
            3: begin
                return T_IN_W'($urandom_range(0, 255));
            end
            default: begin
                return T_IN_W'($urandom_range(0, T_ONE));
            end
        endcase
    endfunction

    function automatic segment_t rand_segment();
        return make_segment(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                            rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                            rand_t_param());
    endfunction

    // ------------------------------------------------------------------
    // Stream drivers and result checking
    // ------------------------------------------------------------------

    // Offer one segment word and record its expected result once accepted.
    task automatic send_segment(input segment_t s);
        if (feed_idle_en && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
        s_tdata  <= pack_segment(s);
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        split_expect_q = {split_expect_q, predict_split(s)};
    endtask

    // Stop offering and wait until every pending split has come back.
    task automatic wait_splits_done();
        s_tvalid <= 1'b0;
        while (split_expect_q.size() != 0) @(posedge aclk);
        repeat (PIPE_DEPTH + 4) @(posedge aclk);
    endtask

    // Print one line per mismatch, up to a cap, and count all of them.
    task automatic report_mismatch(input string msg);
        if (mismatch_count < PRINT_CAP) begin
            $display("%0t ns: mismatch: %s", $time, msg);
        end
        mismatch_count++;
    endtask

    // Result ready: a long hold when asked for, otherwise random stalls.
    initial begin : sink_ready
        forever begin
            if (sink_hold_len > 0) begin
                m_tready <= 1'b0;
                repeat (sink_hold_len) @(posedge aclk);
                sink_hold_len = 0;
            end else if (sink_idle_en && $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    // Compare each accepted result word with the oldest pending split.
    always @(posedge aclk) begin : result_check
        split_word_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (split_expect_q.size() == 0) begin
                report_mismatch($sformatf("result word %h with no split pending", m_tdata));
            end else begin
                want = split_expect_q.pop_front();
                for (int i = 0; i < N_RESULTS; i++) begin
                    if (m_tdata[i*COORD_W +: COORD_W] !== want[i*COORD_W +: COORD_W]) begin
                        report_mismatch($sformatf("%s got %h want %h", FIELD_NAME[i],
                                        m_tdata[i*COORD_W +: COORD_W],
                                        want[i*COORD_W +: COORD_W]));
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Split parameter at zero, the smallest step, one half, just inside one, one, and above one.
    task automatic test_split_param_edges();
        logic [T_IN_W-1:0] t_list [7];
        t_list = '{'0, 17'd1, 17'h0_8000, 17'h0_FFFF, 17'h1_0000, 17'h1_0001, 17'h1_FFFF};
        foreach (t_list[i]) begin
            send_segment(make_segment(32'sh0001_0000, -32'sd131072, 32'sh0003_2000,
                                      32'sh0010_0000, -32'sd524288, 32'sh0000_8000,
                                      32'sh0020_0000, -32'sd65536, t_list[i]));
        end
    endtask

    // Extreme coordinates, including control points outside the 32-bit range.
    task automatic test_extreme_coords();
        coord_t mx, mn;
        mx = 32'sh7FFF_FFFF;
        mn = 32'sh8000_0000;
        send_segment(make_segment('0, '0, '0, '0, '0, '0, '0, '0, '0));
        send_segment(make_segment(mx, mx, mx, mx, mx, mx, mx, mx, 17'h0_8000));
        send_segment(make_segment(mn, mn, mn, mn, mn, mn, mn, mn, 17'h0_8000));
        send_segment(make_segment(mx, mn, mx, mn, mn, mx, mn, mx, 17'h0_4000));
        send_segment(make_segment(mn, mx, mx, mn, mx, mn, mx, mn, 17'h0_C000));
        send_segment(make_segment(mx, mx, mx, mx, mn, mn, mn, mn, 17'h1_FFFF));
        send_segment(make_segment(mn, mn, mx, mx, mx, mx, mx, mn, 17'h0_0001));
    endtask

    // Products that land exactly on a half step, both signs.
    task automatic test_rounding_ties();
        send_segment(make_segment('0, '0, 32'sd1, -32'sd1, 32'sd1, -32'sd1, '0, '0,
                                  17'h0_8000));
        send_segment(make_segment(32'sd3, -32'sd3, -32'sd1, 32'sd1, 32'sd3, -32'sd3,
                                  -32'sd2, 32'sd2, 17'h0_8000));
        send_segment(make_segment('0, '0, 32'sd2, -32'sd2, -32'sd6, 32'sd6, 32'sd1,
                                  -32'sd1, 17'h0_4000));
        send_segment(make_segment(-32'sd5, 32'sd5, 32'sd7, -32'sd7, 32'sd5, -32'sd5,
                                  32'sd9, -32'sd9, 17'h0_C000));
    endtask

    task automatic test_random_segments(input int count);
        for (int i = 0; i < count; i++) begin
            send_segment(rand_segment());
        end
    endtask

    // Hold the result side for a long stretch while words keep coming,
    // so the pipeline fills and the input stalls.
    task automatic test_output_backpressure();
        bit saved_idle;
        saved_idle    = feed_idle_en;
        feed_idle_en  = 1'b0;
        sink_hold_len = 300;
        for (int i = 0; i < 40; i++) begin
            send_segment(rand_segment());
        end
        feed_idle_en = saved_idle;
        wait_splits_done();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_split_param_edges();
        test_extreme_coords();
        test_rounding_ties();
        wait_splits_done();

        feed_idle_en = 1'b1;
        sink_idle_en = 1'b1;
        test_random_segments(300);
        wait_splits_done();

        test_output_backpressure();

        // Last stretch runs at full rate on both sides.
        feed_idle_en = 1'b0;
        sink_idle_en = 1'b0;
        test_random_segments(80);
        wait_splits_done();

        repeat (2 * PIPE_DEPTH) @(posedge aclk);
        if (mismatch_count == 0 && split_expect_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
